FILE: rtl/cbe_pkg.sv
`default_nettype none
package cbe_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned BLOCK_W         = 4 * WORD_W;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned ROUND_COUNT_DEF = 8;

  // key register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t d;
    word_t c;
    word_t b;
    word_t a;
  } cstate_t;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  // first half of a round: one add per lane pair
  function automatic cstate_t half_round_first(input cstate_t s);
    cstate_t r;
    word_t   a_sum;
    word_t   c_sum;
    a_sum = s.a + s.b;
    c_sum = s.c + s.d;
    r.a   = rotl(a_sum, 16);
    r.b   = rotl(s.b, 5) ^ a_sum;
    r.c   = c_sum;
    r.d   = rotl(s.d, 8) ^ c_sum;
    return r;
  endfunction

  // second half of a round
  function automatic cstate_t half_round_second(input cstate_t s);
    cstate_t r;
    word_t   a_sum;
    word_t   c_sum;
    a_sum = s.a + s.d;
    c_sum = s.c + s.b;
    r.a   = a_sum;
    r.d   = rotl(s.d, 13) ^ a_sum;
    r.b   = rotl(s.b, 7) ^ c_sum;
    r.c   = rotl(c_sum, 16);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cbe_round_stage.sv
`default_nettype none
module cbe_round_stage #(
  parameter bit SECOND_HALF = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cbe_pkg::cstate_t in_state,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output cbe_pkg::cstate_t     out_state
);

  logic             valid_r;
  logic             valid_nxt;
  cbe_pkg::cstate_t state_r;
  cbe_pkg::cstate_t state_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    state_nxt = state_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (SECOND_HALF) begin
        state_nxt = cbe_pkg::half_round_second(in_state);
      end else begin
        state_nxt = cbe_pkg::half_round_first(in_state);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign out_valid = valid_r;
  assign out_state = state_r;

endmodule
`default_nettype wire

FILE: rtl/cbe_round_pipe.sv
`default_nettype none
module cbe_round_pipe #(
  parameter int unsigned ROUND_COUNT = cbe_pkg::ROUND_COUNT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cbe_pkg::cstate_t in_state,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cbe_pkg::cstate_t      out_state
);

  localparam int unsigned STAGES = 2 * ROUND_COUNT;

  logic             valid_s [0:STAGES];
  logic             ready_s [0:STAGES];
  cbe_pkg::cstate_t state_s [0:STAGES];

  assign valid_s[0] = in_valid;
  assign state_s[0] = in_state;
  assign in_ready   = ready_s[0];

  // even stages do the first half of a round, odd stages the second
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    cbe_round_stage #(
      .SECOND_HALF ((i % 2) == 1)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_s[i]),
      .in_ready  (ready_s[i]),
      .in_state  (state_s[i]),
      .out_valid (valid_s[i+1]),
      .out_ready (ready_s[i+1]),
      .out_state (state_s[i+1])
    );
  end

  assign ready_s[STAGES] = out_ready;
  assign out_valid       = valid_s[STAGES];
  assign out_state       = state_s[STAGES];

endmodule
`default_nettype wire

FILE: rtl/chaskey_block_encrypt_unit.sv
`default_nettype none
// Channel  | Direction | Handshake          | Payload
// in_      | sink      | in_tvalid/tready   | in_tdata: plaintext block, 4 x 32 bit
// out_     | source    | out_tvalid/tready  | out_tdata: ciphertext block, 4 x 32 bit
// cfg_     | sink      | cfg_valid/ready    | cfg_index, cfg_data: key word write
//
// The path holds one key-whitening register, one register per half
// round and one output whitening register. One item per cycle is
// sustained while out_tready is high; each half round is one 32-bit add deep.
// Reset (rst_n low, synchronous) clears all valid bits and the key to zero.
// A stall on out_tready holds each occupied stage; empty stages keep
// filling, so bubbles close up and nothing is lost or repeated.
// Key writes are always taken (cfg_ready high) and belong in idle time.
module chaskey_block_encrypt_unit #(
  parameter int unsigned ROUND_COUNT = cbe_pkg::ROUND_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata, from bit 0 up: plain_word0, plain_word1, plain_word2, plain_word3
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [cbe_pkg::BLOCK_W-1:0]     in_tdata,
  // out_tdata, from bit 0 up: cipher_word0, cipher_word1, cipher_word2, cipher_word3
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [cbe_pkg::BLOCK_W-1:0]          out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [cbe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cbe_pkg::WORD_W-1:0]      cfg_data
);

  // key registers
  cbe_pkg::word_t   key0_r, key1_r, key2_r, key3_r;
  cbe_pkg::word_t   key0_nxt, key1_nxt, key2_nxt, key3_nxt;

  // input whitening stage
  logic             wv_r, wv_nxt;
  cbe_pkg::cstate_t ws_r, ws_nxt;

  // round pipeline handshake
  logic             pipe_in_ready;
  logic             pipe_out_valid;
  logic             pipe_out_ready;
  cbe_pkg::cstate_t pipe_out_state;

  // output stage
  logic             ov_r, ov_nxt;
  cbe_pkg::cstate_t os_r, os_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    key0_nxt = key0_r;
    key1_nxt = key1_r;
    key2_nxt = key2_r;
    key3_nxt = key3_r;
    if (cfg_valid) begin
      case (cfg_index)
        cbe_pkg::CFG_KEY_WORD0: key0_nxt = cfg_data;
        cbe_pkg::CFG_KEY_WORD1: key1_nxt = cfg_data;
        cbe_pkg::CFG_KEY_WORD2: key2_nxt = cfg_data;
        cbe_pkg::CFG_KEY_WORD3: key3_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !wv_r || pipe_in_ready;

  always_comb begin
    wv_nxt = wv_r;
    ws_nxt = ws_r;
    if (in_tready) begin
      wv_nxt   = in_tvalid;
      ws_nxt.a = in_tdata[0*cbe_pkg::WORD_W +: cbe_pkg::WORD_W] ^ key0_r;
      ws_nxt.b = in_tdata[1*cbe_pkg::WORD_W +: cbe_pkg::WORD_W] ^ key1_r;
      ws_nxt.c = in_tdata[2*cbe_pkg::WORD_W +: cbe_pkg::WORD_W] ^ key2_r;
      ws_nxt.d = in_tdata[3*cbe_pkg::WORD_W +: cbe_pkg::WORD_W] ^ key3_r;
    end
  end

  cbe_round_pipe #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_rounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wv_r),
    .in_ready  (pipe_in_ready),
    .in_state  (ws_r),
    .out_valid (pipe_out_valid),
    .out_ready (pipe_out_ready),
    .out_state (pipe_out_state)
  );

  // final whitening goes straight into the output register
  assign pipe_out_ready = !ov_r || out_tready;

  always_comb begin
    ov_nxt = ov_r;
    os_nxt = os_r;
    if (pipe_out_ready) begin
      ov_nxt   = pipe_out_valid;
      os_nxt.a = pipe_out_state.a ^ key0_r;
      os_nxt.b = pipe_out_state.b ^ key1_r;
      os_nxt.c = pipe_out_state.c ^ key2_r;
      os_nxt.d = pipe_out_state.d ^ key3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      wv_r   <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      key0_r <= key0_nxt;
      key1_r <= key1_nxt;
      key2_r <= key2_nxt;
      key3_r <= key3_nxt;
      wv_r   <= wv_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ws_r <= ws_nxt;
    os_r <= os_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {os_r.d, os_r.c, os_r.b, os_r.a};

endmodule
`default_nettype wire
